### src/url_percent_decoder_top_defines.svh
// assertion helpers for the url percent decoder
`ifndef URL_PERCENT_DECODER_TOP_DEFINES_SVH
`define URL_PERCENT_DECODER_TOP_DEFINES_SVH

// checked property on the block clock, quiet while reset is held
`define ULPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same-cycle implication
`define ULPD_ASSERT_IMP(lbl, ante, cons, msg) \
    `ULPD_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define ULPD_ASSERT_NXT(lbl, ante, cons, msg) \
    `ULPD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### src/ulpd_pkg.sv
package ulpd_pkg;

    localparam logic [7:0] PCT_CHAR  = 8'h25;
    localparam logic [7:0] UPPER_F   = 8'h46;
    localparam logic [7:0] DIGIT_9   = 8'h39;
    localparam logic [7:0] CASE_DIFF = 8'h20;
    localparam logic [7:0] ALPHA_OFS = 8'd55;
    localparam logic [7:0] DIGIT_OFS = 8'd48;

    // output queue sizing
    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
    // a character may be processed while at least two slots are free
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(OUT_DEPTH - 2);

    // escape phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
    } t_out_item;

    // results of one character: count (0..2) and up to two bytes
    typedef struct packed {
        logic [1:0] n;
        t_out_item  item0;
        t_out_item  item1;
    } t_dec_out;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (v > UPPER_F) begin
            v = v - CASE_DIFF;
        end
        if (v > DIGIT_9) begin
            v = v - ALPHA_OFS;
        end else begin
            v = v - DIGIT_OFS;
        end
        return v;
    endfunction

endpackage

### src/ulpd_decode.sv
module ulpd_decode
    import ulpd_pkg::*;
(
    input  t_phase     i_phase,
    input  logic [7:0] i_held,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output t_dec_out   o_res,
    output t_phase     o_phase_nxt,
    output logic [7:0] o_held_nxt
);

    logic [7:0] w_hi;
    logic [7:0] w_lo;
    logic [7:0] w_byte;

    assign w_hi   = digit_value(i_held);
    assign w_lo   = digit_value(i_char);
    assign w_byte = {w_hi[3:0], 4'b0000} | w_lo;

    always_comb begin
        o_res       = '0;
        o_phase_nxt = PH_IDLE;
        o_held_nxt  = '0;
        unique case (i_phase)
            PH_PCT: begin
                if (i_last) begin
                    // string ends after '%x': both pass through
                    o_res.n              = 2'd2;
                    o_res.item0.byte_val = PCT_CHAR;
                    o_res.item0.last     = 1'b0;
                    o_res.item1.byte_val = i_char;
                    o_res.item1.last     = 1'b1;
                end else begin
                    o_held_nxt  = i_char;
                    o_phase_nxt = PH_DIGIT;
                end
            end
            PH_DIGIT: begin
                o_res.n              = 2'd1;
                o_res.item0.byte_val = w_byte;
                o_res.item0.last     = i_last;
            end
            default: begin
                if (i_char == PCT_CHAR && !i_last) begin
                    o_phase_nxt = PH_PCT;
                end else begin
                    o_res.n              = 2'd1;
                    o_res.item0.byte_val = i_char;
                    o_res.item0.last     = i_last;
                end
            end
        endcase
    end

endmodule

### src/ulpd_out_fifo.sv
module ulpd_out_fifo
    import ulpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dec_out         i_push,
    input  logic             i_pop,
    output logic [CNT_W-1:0] o_count,
    output logic             o_valid,
    output t_out_item        o_head
);

    t_out_item        r_mem [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic [PTR_W-1:0] w_wr_ptr1;
    logic             w_pop;

    assign o_valid   = (r_count != '0);
    assign o_count   = r_count;
    assign o_head    = r_mem[r_rd_ptr];
    assign w_pop     = i_pop && o_valid;
    assign w_wr_ptr1 = r_wr_ptr + PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.n);
        n_rd_ptr = r_rd_ptr + PTR_W'(w_pop);
        n_count  = r_count + CNT_W'(i_push.n) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.item1;
        end
    end

endmodule

### src/url_percent_decoder_top.sv
// a character accepted into the input register is decoded from there, and its bytes are
//   written to the output queue, whose head offers the first byte
// throughput: one character per cycle; a four-entry output queue absorbs the second
//   byte of a dangling escape at end of string, and input stalls only when it is nearly full
// reset (i_rst_n low, synchronous): empties input register and output queue,
//   returns the escape phase to idle and clears the held digit
module url_percent_decoder_top
    import ulpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_is_last,
    // decoded byte output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte_out,
    output logic       o_last_out
);

`include "url_percent_decoder_top_defines.svh"

    // input register stage
    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_in_last;
    logic             n_in_valid;

    // escape state
    t_phase           r_phase;
    logic [7:0]       r_held;
    t_phase           w_phase_nxt;
    logic [7:0]       w_held_nxt;

    t_dec_out         w_dec;
    t_dec_out         w_push;
    logic             w_in_fire;
    logic             w_proc_fire;
    logic [CNT_W-1:0] w_count;
    t_out_item        w_head;

    // process the registered character when the queue has room for two bytes
    assign w_proc_fire = r_in_valid && (w_count <= ROOM_LIMIT);
    // accept a new request whenever the input register empties this cycle
    assign o_ready     = !r_in_valid || w_proc_fire;
    assign w_in_fire   = i_valid && o_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_fire) begin
            n_in_valid = 1'b1;
        end else if (w_proc_fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_char <= i_char_in;
            r_in_last <= i_is_last;
        end
    end

    // escape decode, purely combinational
    ulpd_decode u_decode (
        .i_phase     (r_phase),
        .i_held      (r_held),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .o_res       (w_dec),
        .o_phase_nxt (w_phase_nxt),
        .o_held_nxt  (w_held_nxt)
    );

    // state only moves when a character is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (w_proc_fire) begin
            r_phase <= w_phase_nxt;
            r_held  <= w_held_nxt;
        end
    end

    // gate the push when nothing is processed
    always_comb begin
        w_push = w_dec;
        if (!w_proc_fire) begin
            w_push.n = 2'd0;
        end
    end

    // result queue doubles as the output register
    ulpd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (i_ready),
        .o_count (w_count),
        .o_valid (o_valid),
        .o_head  (w_head)
    );

    assign o_byte_out = w_head.byte_val;
    assign o_last_out = w_head.last;

    // two bytes only come from a '%' cut off by end of string
    `ULPD_ASSERT_IMP(a_two_only_after_pct, w_proc_fire && w_dec.n == 2'd2,
        r_phase == PH_PCT && r_in_last, "two bytes outside a dangling escape")
    // the second digit always yields exactly one byte
    `ULPD_ASSERT_IMP(a_digit_one_byte, w_proc_fire && r_phase == PH_DIGIT,
        w_dec.n == 2'd1, "second digit did not give one byte")
    // end of string leaves the escape state idle
    `ULPD_ASSERT_NXT(a_last_resets_phase, w_proc_fire && r_in_last,
        r_phase == PH_IDLE && r_held == 8'h00, "escape state not cleared at end of string")
    // queue never overflows
    `ULPD_ASSERT(a_queue_bound, w_count <= CNT_W'(OUT_DEPTH), "output queue overflow")

endmodule
